/* src/sws_pkg.sv */
// shared types and codes for the sorting stack block
// no dependencies; used by sws_ctrl and stack_with_two_stack_sort
package sws_pkg;

  localparam int unsigned DEPTH_DEF = 1024;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned FILL_W    = 11;

  typedef enum logic [1:0] {
    CMD_PUSH = 2'd0,
    CMD_POP  = 2'd1,
    CMD_PEEK = 2'd2,
    CMD_SORT = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_POPM,
    ST_GETV,
    ST_CMP,
    ST_GETT,
    ST_DRAIN,
    ST_DRGET
  } state_t;

  typedef struct packed {
    logic                     valid;
    logic signed [WORD_W-1:0] data;
    status_t                  status;
    logic [FILL_W-1:0]        fill;
  } res_t;

endpackage

/* src/sws_ram.sv */
// one-write one-read word memory with registered read data
// no dependencies
module sws_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic               clk,
  input  logic               we,
  input  logic [AW-1:0]      waddr,
  input  logic signed [31:0] wdata,
  input  logic [AW-1:0]      raddr,
  output logic signed [31:0] rdata
);

  logic signed [31:0] mem [DEPTH];
  logic signed [31:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* src/sws_ctrl.sv */
// command sequencer: stack counters, the shared compare and the sort passes
// depends on sws_pkg; drives the main and temporary word memories
module sws_ctrl #(
  parameter int unsigned DEPTH = sws_pkg::DEPTH_DEF,
  parameter int unsigned AW    = $clog2(DEPTH),
  parameter int unsigned CW    = $clog2(DEPTH + 1)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_command,
  input  logic signed [31:0] in_value,
  output logic               main_we,
  output logic [AW-1:0]      main_waddr,
  output logic signed [31:0] main_wdata,
  output logic [AW-1:0]      main_raddr,
  input  logic signed [31:0] main_rdata,
  output logic               temp_we,
  output logic [AW-1:0]      temp_waddr,
  output logic signed [31:0] temp_wdata,
  output logic [AW-1:0]      temp_raddr,
  input  logic signed [31:0] temp_rdata,
  output sws_pkg::res_t      res
);

  sws_pkg::state_t    state_r, state_nxt;
  sws_pkg::cmd_t      cmd_r, cmd_nxt;
  logic [CW-1:0]      mcnt_r, mcnt_nxt;
  logic [CW-1:0]      tcnt_r, tcnt_nxt;
  logic signed [31:0] v_r, v_nxt;
  logic signed [31:0] ttop_r, ttop_nxt;

  sws_pkg::cmd_t cmd_in;
  logic [CW-1:0] mcnt_m1, tcnt_m2;
  logic          full, mzero, tzero, tone, tgt;

  assign cmd_in  = sws_pkg::cmd_t'(in_command);
  assign mcnt_m1 = mcnt_r - CW'(1);
  assign tcnt_m2 = tcnt_r - CW'(2);
  assign full    = (mcnt_r == CW'(DEPTH));
  assign mzero   = (mcnt_r == '0);
  assign tzero   = (tcnt_r == '0);
  assign tone    = (tcnt_r == CW'(1));
  // the one compare: temp top greater than the word in hand
  assign tgt     = !tzero && (ttop_r > v_r);

  assign busy = (state_r != sws_pkg::ST_IDLE);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sws_pkg::ST_IDLE: begin
        if (start) begin
          unique case (cmd_in)
            sws_pkg::CMD_PUSH: state_nxt = sws_pkg::ST_IDLE;
            sws_pkg::CMD_POP,
            sws_pkg::CMD_PEEK: state_nxt = mzero ? sws_pkg::ST_IDLE : sws_pkg::ST_RD;
            sws_pkg::CMD_SORT: state_nxt = sws_pkg::ST_POPM;
          endcase
        end
      end
      sws_pkg::ST_RD:    state_nxt = sws_pkg::ST_IDLE;
      sws_pkg::ST_POPM:  state_nxt = mzero ? sws_pkg::ST_DRAIN : sws_pkg::ST_GETV;
      sws_pkg::ST_GETV:  state_nxt = sws_pkg::ST_CMP;
      sws_pkg::ST_CMP: begin
        if (tgt) begin
          state_nxt = tone ? sws_pkg::ST_CMP : sws_pkg::ST_GETT;
        end else begin
          state_nxt = sws_pkg::ST_POPM;
        end
      end
      sws_pkg::ST_GETT:  state_nxt = sws_pkg::ST_CMP;
      sws_pkg::ST_DRAIN: begin
        if (tzero) begin
          state_nxt = sws_pkg::ST_IDLE;
        end else begin
          state_nxt = tone ? sws_pkg::ST_DRAIN : sws_pkg::ST_DRGET;
        end
      end
      sws_pkg::ST_DRGET: state_nxt = sws_pkg::ST_DRAIN;
      default:           state_nxt = sws_pkg::ST_IDLE;
    endcase
  end

  // counters and held words
  always_comb begin
    cmd_nxt  = cmd_r;
    mcnt_nxt = mcnt_r;
    tcnt_nxt = tcnt_r;
    v_nxt    = v_r;
    ttop_nxt = ttop_r;
    unique case (state_r)
      sws_pkg::ST_IDLE: begin
        if (start) begin
          cmd_nxt = cmd_in;
          if (cmd_in == sws_pkg::CMD_PUSH && !full) begin
            mcnt_nxt = mcnt_r + CW'(1);
          end
        end
      end
      sws_pkg::ST_RD: begin
        if (cmd_r == sws_pkg::CMD_POP) begin
          mcnt_nxt = mcnt_m1;
        end
      end
      sws_pkg::ST_POPM: begin
        if (!mzero) begin
          mcnt_nxt = mcnt_m1;
        end
      end
      sws_pkg::ST_GETV: v_nxt = main_rdata;
      sws_pkg::ST_CMP: begin
        if (tgt) begin
          mcnt_nxt = mcnt_r + CW'(1);
          tcnt_nxt = tcnt_r - CW'(1);
        end else begin
          tcnt_nxt = tcnt_r + CW'(1);
          ttop_nxt = v_r;
        end
      end
      sws_pkg::ST_GETT,
      sws_pkg::ST_DRGET: ttop_nxt = temp_rdata;
      sws_pkg::ST_DRAIN: begin
        if (!tzero) begin
          mcnt_nxt = mcnt_r + CW'(1);
          tcnt_nxt = tcnt_r - CW'(1);
        end
      end
      default: ;
    endcase
  end

  // memory controls and result
  always_comb begin
    main_we    = 1'b0;
    main_waddr = mcnt_r[AW-1:0];
    main_wdata = ttop_r;
    main_raddr = mcnt_m1[AW-1:0];
    temp_we    = 1'b0;
    temp_waddr = tcnt_r[AW-1:0];
    temp_wdata = v_r;
    temp_raddr = tcnt_m2[AW-1:0];
    res        = '0;
    res.status = sws_pkg::STAT_OK;
    res.fill   = 11'(mcnt_nxt);
    unique case (state_r)
      sws_pkg::ST_IDLE: begin
        if (start) begin
          unique case (cmd_in)
            sws_pkg::CMD_PUSH: begin
              main_we    = !full;
              main_wdata = in_value;
              res.valid  = 1'b1;
              res.status = full ? sws_pkg::STAT_FULL : sws_pkg::STAT_OK;
            end
            sws_pkg::CMD_POP,
            sws_pkg::CMD_PEEK: begin
              if (mzero) begin
                res.valid  = 1'b1;
                res.status = sws_pkg::STAT_EMPTY;
              end
            end
            sws_pkg::CMD_SORT: ;
          endcase
        end
      end
      sws_pkg::ST_RD: begin
        res.valid = 1'b1;
        res.data  = main_rdata;
      end
      sws_pkg::ST_CMP: begin
        // larger temp top goes back to main, else the word settles on temp
        main_we = tgt;
        temp_we = !tgt;
      end
      sws_pkg::ST_DRAIN: begin
        main_we   = !tzero;
        res.valid = tzero;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sws_pkg::ST_IDLE;
      mcnt_r  <= '0;
      tcnt_r  <= '0;
    end else begin
      state_r <= state_nxt;
      mcnt_r  <= mcnt_nxt;
      tcnt_r  <= tcnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    v_r    <= v_nxt;
    ttop_r <= ttop_nxt;
  end

  a_temp_empty_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sws_pkg::ST_IDLE) |-> tzero)
    else $error("temporary stack not empty while idle");

  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, mcnt_r} + {1'b0, tcnt_r}) <= (CW + 1)'(DEPTH))
    else $error("words held exceed depth");

  a_pop_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sws_pkg::ST_RD && cmd_r == sws_pkg::CMD_POP) |=> (mcnt_r == $past(mcnt_m1)))
    else $error("pop did not remove one word");

  a_res_leaves_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (res.valid && busy) |=> (state_r == sws_pkg::ST_IDLE))
    else $error("result issued mid-operation");

endmodule

/* src/stack_with_two_stack_sort.sv */
// top level of the sorting stack: sequencer, two word memories, result register
// depends on sws_pkg, sws_ctrl and sws_ram
// Commands are taken when start is high and busy is low; each gives one word
// on out_data/out_status/out_fill_count, marked by out_valid for one cycle,
// in the cycle after the command completes. Push, and pop or peek on an empty
// stack, complete in the cycle they are taken, so such commands can follow
// back to back. Pop and peek on a non-empty stack pass through a read state
// because the memory read port is registered. Sort moves words one at a time
// through the temporary memory with a single compare: each word taken off main
// (words moved back are taken off again) is compared with the temp top, larger
// temp words are moved back to main during a pass, and the temp words are
// drained to main at the end. The receiver cannot stall results.
module stack_with_two_stack_sort #(
  parameter int unsigned DEPTH = sws_pkg::DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_command,
  input  logic signed [31:0] in_value,
  output logic               out_valid,
  output logic signed [31:0] out_data,
  output logic [1:0]         out_status,
  output logic [10:0]        out_fill_count
);

  localparam int unsigned AW = $clog2(DEPTH);

  logic               main_we, temp_we;
  logic [AW-1:0]      main_waddr, main_raddr, temp_waddr, temp_raddr;
  logic signed [31:0] main_wdata, main_rdata, temp_wdata, temp_rdata;
  sws_pkg::res_t      res;

  logic               out_valid_r;
  logic signed [31:0] out_data_r;
  logic [1:0]         out_status_r;
  logic [10:0]        out_fill_r;

  sws_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_command (in_command),
    .in_value   (in_value),
    .main_we    (main_we),
    .main_waddr (main_waddr),
    .main_wdata (main_wdata),
    .main_raddr (main_raddr),
    .main_rdata (main_rdata),
    .temp_we    (temp_we),
    .temp_waddr (temp_waddr),
    .temp_wdata (temp_wdata),
    .temp_raddr (temp_raddr),
    .temp_rdata (temp_rdata),
    .res        (res)
  );

  sws_ram #(.DEPTH(DEPTH)) u_main_ram (
    .clk   (clk),
    .we    (main_we),
    .waddr (main_waddr),
    .wdata (main_wdata),
    .raddr (main_raddr),
    .rdata (main_rdata)
  );

  sws_ram #(.DEPTH(DEPTH)) u_temp_ram (
    .clk   (clk),
    .we    (temp_we),
    .waddr (temp_waddr),
    .wdata (temp_wdata),
    .raddr (temp_raddr),
    .rdata (temp_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= res.valid;
    end
  end

  // result word held until the next one
  always_ff @(posedge clk) begin
    if (res.valid) begin
      out_data_r   <= res.data;
      out_status_r <= res.status;
      out_fill_r   <= res.fill;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_data       = out_data_r;
  assign out_status     = out_status_r;
  assign out_fill_count = out_fill_r;

endmodule

/* sim/tb.sv */
// testbench for stack_with_two_stack_sort: push, pop, peek and sort checked word by word
// depends on sws_pkg and the stack_with_two_stack_sort top level
module tb;

  localparam int unsigned DEPTH = sws_pkg::DEPTH_DEF;
  localparam int unsigned RANDOM_WORDS = 450;

  typedef struct {
    logic signed [31:0] data;
    sws_pkg::status_t   status;
    logic [10:0]        fill;
  } result_t;

  logic clk = 1'b0;
  logic rst_n;
  logic start;
  logic busy;
  logic [1:0] in_command;
  logic signed [31:0] in_value;
  logic out_valid;
  logic signed [31:0] out_data;
  logic [1:0] out_status;
  logic [10:0] out_fill_count;

  // back of the queue is the top of the stack
  logic signed [31:0] held_words[$];
  result_t pending_results[$];
  int errors = 0;
  int words_sent = 0;
  bit steady = 1'b0;

  stack_with_two_stack_sort DUT (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_command(in_command),
    .in_value(in_value),
    .out_valid(out_valid),
    .out_data(out_data),
    .out_status(out_status),
    .out_fill_count(out_fill_count)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // largest word at the bottom, smallest on top
  task automatic sort_held();
    logic signed [31:0] key;
    int j;
    for (int i = 1; i < held_words.size(); i++) begin
      key = held_words[i];
      j = i - 1;
      while (j >= 0 && held_words[j] < key) begin
        held_words[j + 1] = held_words[j];
        j--;
      end
      held_words[j + 1] = key;
    end
  endtask

  task automatic apply_command(sws_pkg::cmd_t cmd, logic signed [31:0] val);
    result_t r;
    r.data = '0;
    r.status = sws_pkg::STAT_OK;
    case (cmd)
      sws_pkg::CMD_PUSH: begin
        if (held_words.size() < DEPTH) held_words.push_back(val);
        else r.status = sws_pkg::STAT_FULL;
      end
      sws_pkg::CMD_POP: begin
        if (held_words.size() > 0) r.data = held_words.pop_back();
        else r.status = sws_pkg::STAT_EMPTY;
      end
      sws_pkg::CMD_PEEK: begin
        if (held_words.size() > 0) r.data = held_words[$];
        else r.status = sws_pkg::STAT_EMPTY;
      end
      default: sort_held();
    endcase
    r.fill = 11'(held_words.size());
    pending_results.push_back(r);
  endtask

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_word(sws_pkg::cmd_t cmd, logic signed [31:0] val);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    in_command <= cmd;
    in_value <= val;
    @(posedge clk);
    while (busy) @(posedge clk);
    apply_command(cmd, val);
    words_sent++;
    @(negedge clk);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2, 3: return 32'($urandom_range(0, 6)) - 32'd3;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_op(sws_pkg::cmd_t cmd);
    send_word(cmd, (cmd == sws_pkg::CMD_PUSH) ? pick_value() : $urandom);
  endtask

  task automatic test_empty_stack();
    steady = 1'b1;
    send_word(sws_pkg::CMD_POP, 32'h0);
    send_word(sws_pkg::CMD_PEEK, 32'hffff_ffff);
    send_word(sws_pkg::CMD_SORT, 32'h0);
    steady = 1'b0;
    send_word(sws_pkg::CMD_PUSH, 32'h8000_0000);
    send_word(sws_pkg::CMD_PEEK, 32'h0);
    send_word(sws_pkg::CMD_POP, 32'h0);
    send_word(sws_pkg::CMD_POP, 32'h0);
  endtask

  task automatic test_extreme_words();
    send_word(sws_pkg::CMD_PUSH, 32'h7fff_ffff);
    send_word(sws_pkg::CMD_PUSH, 32'h8000_0000);
    send_word(sws_pkg::CMD_PUSH, 32'h0000_0000);
    send_word(sws_pkg::CMD_PUSH, 32'hffff_ffff);
    send_word(sws_pkg::CMD_PUSH, 32'haaaa_aaaa);
    send_word(sws_pkg::CMD_PUSH, 32'h5555_5555);
    send_word(sws_pkg::CMD_SORT, 32'h0);
    repeat (7) send_word(sws_pkg::CMD_POP, $urandom);
  endtask

  task automatic test_equal_words();
    send_word(sws_pkg::CMD_PUSH, 32'd5);
    send_word(sws_pkg::CMD_PUSH, -32'sd3);
    send_word(sws_pkg::CMD_PUSH, 32'd5);
    send_word(sws_pkg::CMD_PUSH, 32'd5);
    send_word(sws_pkg::CMD_SORT, 32'h0);
    send_word(sws_pkg::CMD_POP, 32'h0);
    send_word(sws_pkg::CMD_PEEK, 32'h0);
  endtask

  task automatic test_fill_to_full();
    while (held_words.size() < DEPTH) begin
      if ($urandom_range(0, 63) == 0) steady = ~steady;
      send_word(sws_pkg::CMD_PUSH, $urandom);
    end
    steady = 1'b0;
    send_word(sws_pkg::CMD_PUSH, $urandom);
    send_word(sws_pkg::CMD_PUSH, 32'h7fff_ffff);
    send_word(sws_pkg::CMD_PEEK, $urandom);
    while (held_words.size() > 0) begin
      if ($urandom_range(0, 63) == 0) steady = ~steady;
      send_word(sws_pkg::CMD_POP, $urandom);
    end
    steady = 1'b0;
    send_word(sws_pkg::CMD_POP, $urandom);
  endtask

  task automatic test_long_sort();
    repeat (64) send_op(sws_pkg::CMD_PUSH);
    send_op(sws_pkg::CMD_SORT);
    repeat (65) send_op(sws_pkg::CMD_POP);
  endtask

  task automatic test_random_mix();
    int first;
    int k;
    int pick;
    first = words_sent;
    while (words_sent - first < RANDOM_WORDS) begin
      if ($urandom_range(0, 39) == 0) steady = ~steady;
      if ($urandom_range(0, 9) < 3 && held_words.size() <= 24) begin
        // build, sort and drain, one extra pop to hit the empty case
        k = $urandom_range(0, 16);
        repeat (k) send_op(sws_pkg::CMD_PUSH);
        send_op(sws_pkg::CMD_SORT);
        if ($urandom_range(0, 1)) send_op(sws_pkg::CMD_PEEK);
        repeat (held_words.size() + 1) send_op(sws_pkg::CMD_POP);
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < ((held_words.size() > 40) ? 20 : 50)) send_op(sws_pkg::CMD_PUSH);
        else if (pick < 75) send_op(sws_pkg::CMD_POP);
        else if (pick < 92) send_op(sws_pkg::CMD_PEEK);
        else send_op(sws_pkg::CMD_SORT);
      end
    end
    steady = 1'b0;
  endtask

  always @(posedge clk) begin : check_results
    result_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result word: data %0d status %0d fill %0d",
               out_data, out_status, out_fill_count);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_data !== want.data) begin
          $error("out_data: expected %0d, got %0d", want.data, out_data);
          errors++;
        end
        if (out_status !== want.status) begin
          $error("out_status: expected %0d, got %0d", want.status, out_status);
          errors++;
        end
        if (out_fill_count !== want.fill) begin
          $error("out_fill_count: expected %0d, got %0d", want.fill, out_fill_count);
          errors++;
        end
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_command = sws_pkg::CMD_PUSH;
    in_value = '0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    test_empty_stack();
    test_extreme_words();
    test_equal_words();
    test_fill_to_full();
    test_long_sort();
    test_random_mix();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #24_000_000;
    $display("timeout with %0d words still expected", pending_results.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule
